// ===== design/dbb_pkg.sv =====
// Shared types and constants for the difference bounding box block.
package dbb_pkg;

  localparam int unsigned MAX_DIM       = 4096;
  localparam int unsigned PIXEL_BITS    = 32;
  localparam int unsigned QUEUE_DEPTH   = 2;

  localparam int unsigned PIX_W         = 32;
  localparam int unsigned DIM_W         = 13;
  localparam int unsigned EDGE_W        = 12;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned CFG_DATA_W    = 32;

  localparam int unsigned CMP_BITS      = (PIXEL_BITS < PIX_W) ? PIXEL_BITS : PIX_W;
  localparam logic [PIX_W-1:0] PIX_MASK = {PIX_W{1'b1}} >> (PIX_W - CMP_BITS);

  localparam logic [DIM_W-1:0] DIM_RST  = 13'd4096;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_COMPARE_MODE = 2'd2,
    CFG_REF_COLOR    = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_value;
    logic [PIX_W-1:0] ref_pixel;
  } dbb_in_t;

  typedef struct packed {
    logic              found;
    logic [DIM_W-1:0]  left;
    logic [DIM_W-1:0]  top;
    logic [EDGE_W-1:0] right;
    logic [EDGE_W-1:0] bottom;
  } dbb_out_t;

  // One classified pixel handed from the front end to the tracker.
  typedef struct packed {
    logic             diff;
    logic             last;
    logic [DIM_W-1:0] col;
    logic [DIM_W-1:0] row;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } dbb_entry_t;

endpackage

// ===== design/dbb_front.sv =====
// Front end: configuration registers, pixel compare and raster position counters.
module dbb_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [dbb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dbb_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_valid,
  input  dbb_pkg::dbb_in_t                    in_data,
  input  logic                                q_full,
  output logic                                q_push,
  output dbb_pkg::dbb_entry_t                 q_entry
);

  logic [dbb_pkg::DIM_W-1:0] width_r, height_r;
  logic                      mode_r;
  logic [dbb_pkg::PIX_W-1:0] color_r;
  logic [dbb_pkg::DIM_W-1:0] col_r, col_nxt, row_r, row_nxt;

  logic [dbb_pkg::DIM_W-1:0] eff_w, eff_h;
  logic [dbb_pkg::PIX_W-1:0] other;
  logic                      row_end, frame_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= dbb_pkg::DIM_RST;
      height_r <= dbb_pkg::DIM_RST;
      mode_r   <= 1'b0;
      color_r  <= '0;
    end else if (cfg_we) begin
      case (dbb_pkg::cfg_idx_t'(cfg_index))
        dbb_pkg::CFG_FRAME_WIDTH:  width_r  <= cfg_data[dbb_pkg::DIM_W-1:0];
        dbb_pkg::CFG_FRAME_HEIGHT: height_r <= cfg_data[dbb_pkg::DIM_W-1:0];
        dbb_pkg::CFG_COMPARE_MODE: mode_r   <= cfg_data[0];
        dbb_pkg::CFG_REF_COLOR:    color_r  <= cfg_data[dbb_pkg::PIX_W-1:0];
        default: ;
      endcase
    end
  end

  // zero acts as one, anything above the limit is clamped
  always_comb begin
    if (width_r == '0)
      eff_w = dbb_pkg::DIM_W'(1);
    else if (32'(width_r) > 32'(dbb_pkg::MAX_DIM))
      eff_w = dbb_pkg::DIM_W'(dbb_pkg::MAX_DIM);
    else
      eff_w = width_r;
    if (height_r == '0)
      eff_h = dbb_pkg::DIM_W'(1);
    else if (32'(height_r) > 32'(dbb_pkg::MAX_DIM))
      eff_h = dbb_pkg::DIM_W'(dbb_pkg::MAX_DIM);
    else
      eff_h = height_r;
  end

  assign other     = mode_r ? color_r : in_data.ref_pixel;
  assign row_end   = ({1'b0, col_r} + 14'd1) >= {1'b0, eff_w};
  assign frame_end = row_end && (({1'b0, row_r} + 14'd1) >= {1'b0, eff_h});

  assign q_push = in_valid && !q_full;

  always_comb begin
    q_entry.diff   = (in_data.pixel_value & dbb_pkg::PIX_MASK) != (other & dbb_pkg::PIX_MASK);
    q_entry.last   = frame_end;
    q_entry.col    = col_r;
    q_entry.row    = row_r;
    q_entry.width  = eff_w;
    q_entry.height = eff_h;
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (q_push) begin
      if (frame_end) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (row_end) begin
        col_nxt = '0;
        row_nxt = row_r + dbb_pkg::DIM_W'(1);
      end else begin
        col_nxt = col_r + dbb_pkg::DIM_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

`ifndef SYNTHESIS
  a_frame_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    q_push && frame_end |=> col_r == '0 && row_r == '0)
    else $error("position counters not cleared after frame end");
`endif

endmodule

// ===== design/dbb_queue.sv =====
// Small FIFO of classified pixels between front end and tracker.
module dbb_queue #(
  parameter int unsigned DEPTH = dbb_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  dbb_pkg::dbb_entry_t push_entry,
  output logic                full,
  input  logic                pop,
  output logic                head_valid,
  output dbb_pkg::dbb_entry_t head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  dbb_pkg::dbb_entry_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full       = count_r == CNT_W'(DEPTH);
  assign head_valid = count_r != '0;
  assign head       = entries[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push)
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    if (pop)
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    if (push && !pop)
      count_nxt = count_r + CNT_W'(1);
    else if (pop && !push)
      count_nxt = count_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (push)
      entries[wr_ptr_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count exceeds depth");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("pop from empty queue");
`endif

endmodule

// ===== design/dbb_back.sv =====
// Tracker: folds classified pixels into the box and registers the frame result.
module dbb_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                head_valid,
  input  dbb_pkg::dbb_entry_t head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output dbb_pkg::dbb_out_t   out_data
);

  logic                      any_r, any_nxt;
  logic [dbb_pkg::DIM_W-1:0] min_col_r, min_col_nxt, min_row_r, min_row_nxt;
  logic [dbb_pkg::DIM_W-1:0] max_col_r, max_col_nxt, max_row_r, max_row_nxt;
  logic                      out_valid_r, out_valid_nxt;
  dbb_pkg::dbb_out_t         out_r, out_nxt;

  logic                      hit, any_m;
  logic [dbb_pkg::DIM_W-1:0] min_col_m, min_row_m, max_col_m, max_row_m;

  // a frame's last pixel waits only if the result register is still held
  assign pop = head_valid && (!head.last || !out_valid_r || !out_stall);
  assign hit = head.diff;

  always_comb begin
    any_m     = any_r | hit;
    min_col_m = min_col_r;
    min_row_m = min_row_r;
    max_col_m = max_col_r;
    max_row_m = max_row_r;
    if (hit) begin
      min_col_m = (!any_r || head.col < min_col_r) ? head.col : min_col_r;
      min_row_m = (!any_r || head.row < min_row_r) ? head.row : min_row_r;
      max_col_m = (!any_r || head.col > max_col_r) ? head.col : max_col_r;
      max_row_m = (!any_r || head.row > max_row_r) ? head.row : max_row_r;
    end
  end

  always_comb begin
    any_nxt       = any_r;
    min_col_nxt   = min_col_r;
    min_row_nxt   = min_row_r;
    max_col_nxt   = max_col_r;
    max_row_nxt   = max_row_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (pop) begin
      if (head.last) begin
        out_valid_nxt  = 1'b1;
        out_nxt.found  = any_m;
        out_nxt.left   = any_m ? min_col_m : head.width;
        out_nxt.top    = any_m ? min_row_m : head.height;
        out_nxt.right  = any_m ? max_col_m[dbb_pkg::EDGE_W-1:0] : '0;
        out_nxt.bottom = any_m ? max_row_m[dbb_pkg::EDGE_W-1:0] : '0;
        any_nxt        = 1'b0;
        min_col_nxt    = '0;
        min_row_nxt    = '0;
        max_col_nxt    = '0;
        max_row_nxt    = '0;
      end else begin
        any_nxt     = any_m;
        min_col_nxt = min_col_m;
        min_row_nxt = min_row_m;
        max_col_nxt = max_col_m;
        max_row_nxt = max_row_m;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      any_r       <= 1'b0;
      min_col_r   <= '0;
      min_row_r   <= '0;
      max_col_r   <= '0;
      max_row_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      any_r       <= any_nxt;
      min_col_r   <= min_col_nxt;
      min_row_r   <= min_row_nxt;
      max_col_r   <= max_col_nxt;
      max_row_r   <= max_row_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(pop && head.last))
    else $error("result raised without a frame end");
  a_empty_box: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.found |-> out_r.right == '0 && out_r.bottom == '0)
    else $error("empty frame reports a nonzero far edge");
  a_box_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    any_r |-> min_col_r <= max_col_r && min_row_r <= max_row_r)
    else $error("tracked box is inverted");
`endif

endmodule

// ===== design/difference_bounding_box_top.sv =====
// Top level of the difference bounding box block: front end, queue and tracker.
// Throughput: one pixel per cycle, sustained while the result side keeps up.
// The result is registered: the frame's last pixel is written into the queue,
// and is folded into the result register when it is popped from the queue head.
// A held result blocks the next last pixel at the queue head; one more fits behind.
// Reset (synchronous, rst_n low): config to defaults, counters and box cleared.
module difference_bounding_box_top #(
  parameter int unsigned QUEUE_DEPTH = dbb_pkg::QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [dbb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dbb_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  dbb_pkg::dbb_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output dbb_pkg::dbb_out_t              out_data
);

  logic                q_full, q_push, q_pop, q_head_valid;
  dbb_pkg::dbb_entry_t q_entry, q_head;

  assign in_stall = q_full;

  dbb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (q_entry)
  );

  dbb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  dbb_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule
